// File: sv/fss_pkg.sv
// Package for the fuzzy subsequence scorer.
// Holds request codes, score constants and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_NAME   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    localparam int CHAR_W  = 16;
    localparam int SCORE_W = 14;   // signed result width
    localparam int RUN_W   = 10;   // run bonus register width
    localparam int ACC_W   = 13;   // running score register width

    typedef logic [CHAR_W-1:0]         char_t;
    typedef logic signed [SCORE_W-1:0] score_t;

    localparam int SCORE_EMPTY  = 100;
    localparam int SCORE_EXACT  = 1000;
    localparam int SCORE_PREFIX = 500;
    localparam int SCORE_HIT    = 10;
    localparam int SCORE_ALIGN  = 5;
    localparam int SCORE_SUBSTR = 50;
    localparam int RUN_STEP     = 10;
    localparam int SCORE_CAP    = 6000;
    localparam int RUN_CAP      = 1023;

endpackage

`default_nettype wire

// File: sv/fuzzy_subsequence_scorer_top.sv
// Fuzzy subsequence scorer, top level.
// Depends on fss_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock. A transaction is registered at the input, then
// the needle compare, the score update and the result go through combinational
// logic into the state registers and the output register, so a result shows on
// m_valid once its last name character leaves the input register. The needle is held
// in MAX_NEEDLE registers compared in parallel against each character; the
// rate is set only by the output register draining (a name-final character that
// reaches the input register while a result still waits on m_ready stalls the
// input until that result is taken; no other transaction ever stalls).
module fuzzy_subsequence_scorer_top
    import fss_pkg::*;
#(
    parameter int MAX_NEEDLE = 32,
    parameter int MAX_NAME   = 255
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_req_type,
    input  wire logic [CHAR_W-1:0]         s_char_code,
    input  wire logic                      s_name_last,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [SCORE_W-1:0]      m_match_score,
    output logic                           m_is_match,
    output logic                           m_needle_overflowed,
    output logic                           m_name_overflowed
);

    localparam int LW    = $clog2(MAX_NEEDLE + 1);             // needle length / pointer
    localparam int IW    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int IDX_N = 2 ** IW;
    localparam int PW    = $clog2(MAX_NAME + 1);               // name position
    localparam int CW    = (PW > LW) ? PW : LW;                // common compare width

    // input register
    logic  in_valid_reg;
    req_t  in_req_reg;
    char_t in_char_reg;
    logic  in_last_reg;

    // needle
    char_t           needle_store [MAX_NEEDLE];
    logic [LW-1:0]   needle_len_reg, needle_len_next;
    logic            needle_full_reg, needle_full_next;

    // per-name state
    logic [LW-1:0]         needle_ptr_reg, needle_ptr_next;
    logic [PW-1:0]         adj_pos_reg, adj_pos_next;   // last hit position + 1
    logic [RUN_W-1:0]      run_bonus_reg, run_bonus_next;
    logic [ACC_W-1:0]      score_reg, score_next;
    logic [PW-1:0]         name_pos_reg, name_pos_next;
    logic                  prefix_ok_reg, prefix_ok_next;
    logic [MAX_NEEDLE-1:0] sub_vec_reg, sub_vec_next;
    logic                  sub_seen_reg, sub_seen_next;
    logic                  name_long_reg, name_long_next;

    // output register
    logic   m_valid_reg;
    score_t out_score_reg, out_score_next;
    logic   out_needle_ovf_reg;
    logic   out_name_ovf_reg;

    // handshake
    logic gives_result;
    logic out_free;
    logic advance;

    // datapath
    logic [IDX_N-1:0]      hits;
    logic [CW-1:0]         pos_ext, len_ext, ptr_ext, pos_next_ext;
    logic                  pos_ok;
    logic                  ptr_hit;
    logic                  adjacent;
    logic [RUN_W:0]        bonus_sum;
    logic [RUN_W-1:0]      bonus_sat;
    logic [SCORE_W-1:0]    hit_sum;
    logic [ACC_W-1:0]      hit_sat;
    logic [MAX_NEEDLE-1:0] sub_vec_new;
    logic [IDX_N-1:0]      sub_pad;
    logic [LW-1:0]         len_m1;
    logic [SCORE_W-1:0]    final_sum;
    logic                  name_clear;

    assign gives_result = in_valid_reg && (in_req_reg == REQ_NAME) && in_last_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign advance      = in_valid_reg && (out_free || !gives_result);
    assign s_ready      = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg  <= req_t'(s_req_type);
            in_char_reg <= s_char_code;
            in_last_reg <= s_name_last;
        end
    end

    // parallel compare against every stored needle character
    always_comb begin
        hits = '0;
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            hits[j] = (LW'(j) < needle_len_reg) && (needle_store[j] == in_char_reg);
        end
    end

    always_comb begin
        needle_len_next  = needle_len_reg;
        needle_full_next = needle_full_reg;
        needle_ptr_next  = needle_ptr_reg;
        adj_pos_next     = adj_pos_reg;
        run_bonus_next   = run_bonus_reg;
        score_next       = score_reg;
        name_pos_next    = name_pos_reg;
        prefix_ok_next   = prefix_ok_reg;
        sub_vec_next     = sub_vec_reg;
        sub_seen_next    = sub_seen_reg;
        name_long_next   = name_long_reg;
        name_clear       = 1'b0;
        out_score_next   = '1;

        pos_ext  = CW'(name_pos_reg);
        len_ext  = CW'(needle_len_reg);
        ptr_ext  = CW'(needle_ptr_reg);
        pos_ok   = name_pos_reg < PW'(MAX_NAME);
        ptr_hit  = (needle_ptr_reg < needle_len_reg) && hits[needle_ptr_reg[IW-1:0]];
        adjacent = name_pos_reg == adj_pos_reg;

        bonus_sum = {1'b0, run_bonus_reg} + (RUN_W + 1)'(RUN_STEP);
        bonus_sat = (bonus_sum > (RUN_W + 1)'(RUN_CAP)) ? RUN_W'(RUN_CAP)
                                                        : bonus_sum[RUN_W-1:0];
        // nested saturating adds with one cap collapse into one sum and one clamp
        hit_sum = SCORE_W'(score_reg) + SCORE_W'(SCORE_HIT)
                + (adjacent ? SCORE_W'(bonus_sat) : '0)
                + ((pos_ext == ptr_ext) ? SCORE_W'(SCORE_ALIGN) : '0);
        hit_sat = (hit_sum > SCORE_W'(SCORE_CAP)) ? ACC_W'(SCORE_CAP) : hit_sum[ACC_W-1:0];

        sub_vec_new = ((sub_vec_reg << 1) | MAX_NEEDLE'(1)) & hits[MAX_NEEDLE-1:0];
        sub_pad     = IDX_N'(sub_vec_new);
        len_m1      = needle_len_reg - LW'(1);

        unique case (in_req_reg)
            REQ_CLEAR: begin
                needle_len_next  = '0;
                needle_full_next = 1'b0;
                name_clear       = 1'b1;
            end
            REQ_APPEND: begin
                if (needle_len_reg < LW'(MAX_NEEDLE)) begin
                    needle_len_next = needle_len_reg + LW'(1);
                end else begin
                    needle_full_next = 1'b1;
                end
                name_clear = 1'b1;
            end
            REQ_NAME: begin
                if (!pos_ok) begin
                    name_long_next = 1'b1;
                end else begin
                    if ((pos_ext < len_ext) && !hits[pos_ext[IW-1:0]]) begin
                        prefix_ok_next = 1'b0;
                    end
                    if (ptr_hit) begin
                        score_next      = hit_sat;
                        run_bonus_next  = adjacent ? bonus_sat : '0;
                        adj_pos_next    = name_pos_reg + PW'(1);
                        needle_ptr_next = needle_ptr_reg + LW'(1);
                    end
                    sub_vec_next = sub_vec_new;
                    if ((needle_len_reg != '0) && sub_pad[len_m1[IW-1:0]]) begin
                        sub_seen_next = 1'b1;
                    end
                    name_pos_next = name_pos_reg + PW'(1);
                end
                name_clear = in_last_reg;
            end
            default: begin
            end
        endcase

        // score of the name as it stands after this character
        pos_next_ext = CW'(name_pos_next);
        final_sum = SCORE_W'(score_next) + (sub_seen_next ? SCORE_W'(SCORE_SUBSTR) : '0);
        if (needle_len_reg == '0) begin
            out_score_next = score_t'(SCORE_EMPTY);
        end else if (prefix_ok_next && (pos_next_ext == len_ext)) begin
            out_score_next = score_t'(SCORE_EXACT);
        end else if (prefix_ok_next && (pos_next_ext > len_ext)) begin
            out_score_next = score_t'(SCORE_PREFIX);
        end else if (needle_ptr_next < needle_len_reg) begin
            out_score_next = '1;
        end else if (final_sum > SCORE_W'(SCORE_CAP)) begin
            out_score_next = score_t'(SCORE_CAP);
        end else begin
            out_score_next = score_t'(final_sum);
        end

        if (name_clear) begin
            needle_ptr_next = '0;
            adj_pos_next    = '0;
            run_bonus_next  = '0;
            score_next      = '0;
            name_pos_next   = '0;
            prefix_ok_next  = 1'b1;
            sub_vec_next    = '0;
            sub_seen_next   = 1'b0;
            name_long_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (in_req_reg == REQ_APPEND) && (needle_len_reg < LW'(MAX_NEEDLE))) begin
            needle_store[needle_len_reg[IW-1:0]] <= in_char_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_len_reg  <= '0;
            needle_full_reg <= 1'b0;
            needle_ptr_reg  <= '0;
            adj_pos_reg     <= '0;
            run_bonus_reg   <= '0;
            score_reg       <= '0;
            name_pos_reg    <= '0;
            prefix_ok_reg   <= 1'b1;
            sub_vec_reg     <= '0;
            sub_seen_reg    <= 1'b0;
            name_long_reg   <= 1'b0;
        end else if (advance) begin
            needle_len_reg  <= needle_len_next;
            needle_full_reg <= needle_full_next;
            needle_ptr_reg  <= needle_ptr_next;
            adj_pos_reg     <= adj_pos_next;
            run_bonus_reg   <= run_bonus_next;
            score_reg       <= score_next;
            name_pos_reg    <= name_pos_next;
            prefix_ok_reg   <= prefix_ok_next;
            sub_vec_reg     <= sub_vec_next;
            sub_seen_reg    <= sub_seen_next;
            name_long_reg   <= name_long_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && gives_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && gives_result) begin
            out_score_reg      <= out_score_next;
            out_needle_ovf_reg <= needle_full_next;
            out_name_ovf_reg   <= name_long_reg || !pos_ok;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_match_score       = out_score_reg;
    assign m_is_match          = !out_score_reg[SCORE_W-1];
    assign m_needle_overflowed = out_needle_ovf_reg;
    assign m_name_overflowed   = out_name_ovf_reg;

endmodule

`default_nettype wire
